// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL of the code-to-Unicode map table.
// Depends on nothing; the files that check their logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: post must hold whenever pre holds
`define CUMT_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("%m: check failed");

// Next-cycle implication: post must hold in the cycle after pre
`define CUMT_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("%m: check failed");

`else

`define CUMT_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define CUMT_ASSERT_NXT(lbl, clk, rst_n, pre, post)

`endif

`endif

// ----- sv/cumt_pkg.sv -----
// Shared types and constants of the code-to-Unicode map table.
// No dependencies; used by the channel interfaces and the top level.
package cumt_pkg;

    localparam int CODE_W     = 24;
    localparam int VAL_W      = 21;
    localparam int LIMIT_W    = 4;
    localparam int MAX_OUT    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [LIMIT_W-1:0] RESET_LIMIT = LIMIT_W'(MAX_OUT);

    typedef enum logic {
        ACT_STORE  = 1'b0,
        ACT_LOOKUP = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_IDENT = 2'd3
    } t_status;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_IDENTITY = 1'b0;
    localparam t_cfg_idx CFG_LIMIT    = 1'b1;

endpackage

// ----- sv/cumt_if.sv -----
// Valid/ready channels of the code-to-Unicode map table: request and result.
// Depends on cumt_pkg for field widths and codes.
interface cumt_in_if
    import cumt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    t_action               action;
    logic [CODE_W-1:0]     code;
    logic [VAL_W-1:0]      value;
    logic                  run_end;

    modport source (output valid, action, code, value, run_end, input ready);
    modport sink   (input valid, action, code, value, run_end, output ready);
endinterface

interface cumt_out_if
    import cumt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [VAL_W-1:0]      result_value;
    logic                  found;
    t_status               status;
    logic                  last;

    modport source (output valid, result_value, found, status, last, input ready);
    modport sink   (input valid, result_value, found, status, last, output ready);
endinterface

// ----- sv/code_to_unicode_map_table_unit.sv -----
// Code-to-Unicode map table: direct table per code plus a searched string store.
// After reset a clearing pass zeroes the direct table, with no item taken.
// A store item without run end is buffered in S_DECODE; a direct lookup or one-value commit goes
// through S_DECODE and S_EMIT to the output register. String search scans the code store one
// entry per cycle, then a commit copies one value per cycle or a lookup streams one value per cycle
// while the result side takes them. One item at a time. Depends on cumt_pkg, cumt_if.
`include "assert_macros.svh"

module code_to_unicode_map_table_unit
    import cumt_pkg::*;
#(
    parameter int TABLE_DEPTH    = 65536,
    parameter int STRING_ENTRIES = 64,
    parameter int MAX_STRING     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    cumt_in_if.sink               i_req,
    cumt_out_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW     = $clog2(TABLE_DEPTH);
    localparam int IW     = (STRING_ENTRIES > 1) ? $clog2(STRING_ENTRIES) : 1;
    localparam int CW     = $clog2(STRING_ENTRIES + 1);
    localparam int SW     = $clog2(MAX_STRING);
    localparam int LW     = $clog2(MAX_STRING + 1);
    localparam int SDEPTH = 1 << IW;
    localparam int VDEPTH = 1 << (IW + SW);

    localparam logic [CODE_W:0] TD_LIMIT = (CODE_W + 1)'(TABLE_DEPTH);
    localparam logic [AW-1:0]   CLR_LAST = AW'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_SEARCH,
        S_COPY,
        S_EMIT,
        S_STREAM
    } t_state;

    // Sequencer and control registers
    t_state               r_state,      n_state;
    logic [AW-1:0]        r_clr_addr,   n_clr_addr;
    logic                 r_identity,   n_identity;
    logic [LIMIT_W-1:0]   r_limit,      n_limit;
    t_action              r_action,     n_action;
    logic [CODE_W-1:0]    r_code,       n_code;
    logic [VAL_W-1:0]     r_value,      n_value;
    logic                 r_run_end,    n_run_end;
    logic [LW-1:0]        r_pcount,     n_pcount;
    logic [CW-1:0]        r_scount,     n_scount;
    logic [CW-1:0]        r_idx,        n_idx;
    logic [SW-1:0]        r_j,          n_j;
    logic [LW-1:0]        r_n,          n_n;
    logic                 r_is_store,   n_is_store;
    logic [VAL_W-1:0]     r_res_value,  n_res_value;
    logic                 r_res_found,  n_res_found;
    t_status              r_res_status, n_res_status;
    logic                 r_out_valid,  n_out_valid;
    logic [VAL_W-1:0]     r_out_value,  n_out_value;
    logic                 r_out_found,  n_out_found;
    t_status              r_out_status, n_out_status;
    logic                 r_out_last,   n_out_last;

    // Storage
    logic [VAL_W-1:0]     r_direct_mem [TABLE_DEPTH];
    logic [CODE_W-1:0]    r_scode_mem  [SDEPTH];
    logic [LW-1:0]        r_slen_mem   [SDEPTH];
    logic [VAL_W-1:0]     r_sval_mem   [VDEPTH];
    logic [VAL_W-1:0]     r_pv         [MAX_STRING];
    logic [VAL_W-1:0]     r_rd_dir;
    logic [CODE_W-1:0]    r_rd_code;
    logic [LW-1:0]        r_rd_len;
    logic [VAL_W-1:0]     r_rd_val;

    // Combinational controls
    logic                 w_in_acc;
    logic                 w_out_free;
    logic                 w_code_oor;
    logic [LW-1:0]        w_pnext;
    logic                 w_pspace;
    logic [LIMIT_W-1:0]   w_lim8;
    logic [4:0]           w_len5;
    logic [4:0]           w_lim5;
    logic [4:0]           w_take;
    logic                 w_jlast;
    logic                 w_dir_we;
    logic [AW-1:0]        w_dir_waddr;
    logic [VAL_W-1:0]     w_dir_wdata;
    logic                 w_str_we;
    logic                 w_val_we;
    logic                 w_pv_we;

    assign i_req.ready        = (r_state == S_IDLE);
    assign w_in_acc           = i_req.valid && (r_state == S_IDLE);
    assign w_out_free         = !r_out_valid || o_rsp.ready;
    assign w_code_oor         = ({1'b0, r_code} >= TD_LIMIT);
    assign w_pspace           = (r_pcount < LW'(MAX_STRING));
    assign w_pnext            = w_pspace ? (r_pcount + LW'(1)) : r_pcount;
    assign w_lim8             = (r_limit > LIMIT_W'(MAX_OUT)) ? LIMIT_W'(MAX_OUT) : r_limit;
    assign w_len5             = 5'(r_rd_len);
    assign w_lim5             = 5'(w_lim8);
    assign w_take             = (w_len5 < w_lim5) ? w_len5 : w_lim5;
    assign w_jlast            = ((LW'(r_j) + LW'(1)) == r_n);

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.found        = r_out_found;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.last         = r_out_last;

    // Next-state and datapath control
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_identity   = r_identity;
        n_limit      = r_limit;
        n_action     = r_action;
        n_code       = r_code;
        n_value      = r_value;
        n_run_end    = r_run_end;
        n_pcount     = r_pcount;
        n_scount     = r_scount;
        n_idx        = r_idx;
        n_j          = r_j;
        n_n          = r_n;
        n_is_store   = r_is_store;
        n_res_value  = r_res_value;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_dir_we     = 1'b0;
        w_dir_waddr  = r_code[AW-1:0];
        w_dir_wdata  = '0;
        w_str_we     = 1'b0;
        w_val_we     = 1'b0;
        w_pv_we      = 1'b0;

        // Drop the result once the sink takes it
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        // Configuration writes
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDENTITY: n_identity = i_cfg_data[0];
                CFG_LIMIT:    n_limit    = i_cfg_data[LIMIT_W-1:0];
                default:      n_identity = r_identity;
            endcase
        end

        unique case (r_state)
            S_CLEAR: begin
                w_dir_we    = 1'b1;
                w_dir_waddr = r_clr_addr;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + AW'(1);
                end
            end

            S_IDLE: begin
                if (w_in_acc) begin
                    n_action  = i_req.action;
                    n_code    = i_req.code;
                    n_value   = i_req.value;
                    n_run_end = i_req.run_end;
                    n_state   = S_DECODE;
                end
            end

            S_DECODE: begin
                n_res_value  = '0;
                n_res_found  = 1'b0;
                n_res_status = ST_OK;
                n_idx        = '0;
                if (r_action == ACT_STORE) begin
                    if (r_identity) begin
                        n_pcount     = '0;
                        n_res_status = ST_IDENT;
                        n_state      = r_run_end ? S_EMIT : S_IDLE;
                    end else begin
                        // Buffer the value; extra values of a long run are dropped
                        w_pv_we  = w_pspace;
                        n_pcount = w_pnext;
                        if (!r_run_end) begin
                            n_state = S_IDLE;
                        end else begin
                            n_pcount = '0;
                            n_n      = w_pnext;
                            if (w_code_oor) begin
                                n_res_status = ST_RANGE;
                                n_state      = S_EMIT;
                            end else if (w_pnext <= LW'(1)) begin
                                w_dir_we    = 1'b1;
                                w_dir_wdata = r_value;
                                n_state     = S_EMIT;
                            end else begin
                                n_is_store = 1'b1;
                                n_state    = S_SEARCH;
                            end
                        end
                    end
                end else begin
                    if (r_identity) begin
                        n_res_value = r_code[VAL_W-1:0];
                        n_res_found = 1'b1;
                        n_state     = S_EMIT;
                    end else if (w_code_oor) begin
                        n_res_status = ST_RANGE;
                        n_state      = S_EMIT;
                    end else if (r_rd_dir != '0) begin
                        n_res_value = r_rd_dir;
                        n_res_found = 1'b1;
                        n_state     = S_EMIT;
                    end else begin
                        n_is_store = 1'b0;
                        n_state    = S_SEARCH;
                    end
                end
            end

            S_SEARCH: begin
                // One stored code compared per cycle
                if (r_idx == r_scount) begin
                    if (!r_is_store) begin
                        n_state = S_EMIT;
                    end else if (r_scount == CW'(STRING_ENTRIES)) begin
                        n_res_status = ST_FULL;
                        n_state      = S_EMIT;
                    end else begin
                        n_scount = r_scount + CW'(1);
                        n_j      = '0;
                        n_state  = S_COPY;
                    end
                end else if (r_rd_code == r_code) begin
                    if (r_is_store) begin
                        n_j     = '0;
                        n_state = S_COPY;
                    end else if (w_take == 5'd0) begin
                        n_state = S_EMIT;
                    end else begin
                        n_n     = LW'(w_take);
                        n_j     = '0;
                        n_state = S_STREAM;
                    end
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end

            S_COPY: begin
                // Copy one pending value per cycle; first cycle writes code and length and zeroes the direct entry
                w_val_we = 1'b1;
                if (r_j == '0) begin
                    w_str_we = 1'b1;
                    w_dir_we = 1'b1;
                end
                if (w_jlast) begin
                    n_state = S_EMIT;
                end else begin
                    n_j = r_j + SW'(1);
                end
            end

            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res_value;
                    n_out_found  = r_res_found;
                    n_out_status = r_res_status;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            S_STREAM: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_rd_val;
                    n_out_found  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_last   = w_jlast;
                    if (w_jlast) begin
                        n_state = S_IDLE;
                    end else begin
                        n_j = r_j + SW'(1);
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_identity  <= 1'b0;
            r_limit     <= RESET_LIMIT;
            r_pcount    <= '0;
            r_scount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_identity  <= n_identity;
            r_limit     <= n_limit;
            r_pcount    <= n_pcount;
            r_scount    <= n_scount;
            r_out_valid <= n_out_valid;
        end
        r_action     <= n_action;
        r_code       <= n_code;
        r_value      <= n_value;
        r_run_end    <= n_run_end;
        r_idx        <= n_idx;
        r_j          <= n_j;
        r_n          <= n_n;
        r_is_store   <= n_is_store;
        r_res_value  <= n_res_value;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // Pending run buffer
    always_ff @(posedge i_clk) begin
        if (w_pv_we) begin
            r_pv[r_pcount[SW-1:0]] <= r_value;
        end
    end

    // Direct table: one write port, registered read at the next code
    always_ff @(posedge i_clk) begin
        if (w_dir_we) begin
            r_direct_mem[w_dir_waddr] <= w_dir_wdata;
        end
        r_rd_dir <= r_direct_mem[n_code[AW-1:0]];
    end

    // String codes and lengths, read ahead at the next search index
    always_ff @(posedge i_clk) begin
        if (w_str_we) begin
            r_scode_mem[r_idx[IW-1:0]] <= r_code;
            r_slen_mem[r_idx[IW-1:0]]  <= r_n;
        end
        r_rd_code <= r_scode_mem[n_idx[IW-1:0]];
        r_rd_len  <= r_slen_mem[n_idx[IW-1:0]];
    end

    // String values, one row of slots per entry
    always_ff @(posedge i_clk) begin
        if (w_val_we) begin
            r_sval_mem[{r_idx[IW-1:0], r_j}] <= r_pv[r_j];
        end
        r_rd_val <= r_sval_mem[{n_idx[IW-1:0], n_j}];
    end

    // Checks
    `CUMT_ASSERT_IMP(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR, !r_out_valid)
    `CUMT_ASSERT_IMP(a_miss_is_last, i_clk, i_rst_n, r_out_valid && !r_out_found, r_out_last)
    `CUMT_ASSERT_IMP(a_pend_bound, i_clk, i_rst_n, 1'b1, r_pcount <= LW'(MAX_STRING))
    `CUMT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_scount <= CW'(STRING_ENTRIES))
    `CUMT_ASSERT_IMP(a_stream_len, i_clk, i_rst_n, r_state == S_STREAM, LW'(r_j) < r_n)
    `CUMT_ASSERT_NXT(a_emit_loads, i_clk, i_rst_n, r_state == S_EMIT && w_out_free, r_out_valid && r_out_last)

endmodule

// ----- bench/tb_code_to_unicode_map_table_unit.sv -----
`timescale 1ns / 100ps
// Testbench for code_to_unicode_map_table_unit: directed and random store runs and lookups.
// The expected results come from an in-bench table tracker and are checked result by result.
// Depends on cumt_pkg, the cumt_in_if/cumt_out_if channels and the top level of the block.

module tb_code_to_unicode_map_table_unit;
    import cumt_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int MAP_DEPTH       = 65536;
    localparam int STR_SLOTS       = 64;
    localparam int STR_MAX         = 8;
    localparam int SETTLE_CYCLES   = 100;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_CYCLES = 1_000_000;
    localparam logic [CODE_W-1:0] CODE_TOP = '1;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             found;
        t_status          status;
        logic             last;
    } t_map_result;

    // Tracks the direct table, the string store and the open run; queues expected results
    class cmap_tracker;
        bit [VAL_W-1:0]  direct_map [MAP_DEPTH];
        bit [CODE_W-1:0] str_code [STR_SLOTS];
        int              str_len [STR_SLOTS];
        bit [VAL_W-1:0]  str_vals [STR_SLOTS][STR_MAX];
        int              str_count;
        bit [VAL_W-1:0]  run_vals [STR_MAX];
        int              run_len;
        bit              ident;
        int              limit = MAX_OUT;
        t_map_result     expected_unicode [$];
        int              errors;
        int              n_results;
        int              n_hits;
        int              n_string_vals;
        int              n_range;
        int              n_full;
        int              n_ident;

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IDENTITY)
                ident = data[0];
            else
                limit = data;
        endfunction

        function void add_expect(logic [VAL_W-1:0] v, logic f, t_status s, logic l);
            expected_unicode.push_back('{value: v, found: f, status: s, last: l});
            if (s == ST_RANGE) n_range++;
            if (s == ST_FULL) n_full++;
            if (s == ST_IDENT) n_ident++;
        endfunction

        function int find_string(logic [CODE_W-1:0] code);
            for (int i = 0; i < str_count; i++)
                if (str_code[i] == code)
                    return i;
            return -1;
        endfunction

        function t_status commit_run(logic [CODE_W-1:0] code);
            int slot;
            if (code >= MAP_DEPTH)
                return ST_RANGE;
            if (run_len <= 1) begin
                direct_map[code] = (run_len == 1) ? run_vals[0] : '0;
                return ST_OK;
            end
            slot = find_string(code);
            if (slot < 0) begin
                if (str_count >= STR_SLOTS)
                    return ST_FULL;
                slot = str_count;
                str_count++;
            end
            direct_map[code] = '0;
            str_code[slot] = code;
            str_len[slot] = run_len;
            for (int j = 0; j < run_len; j++)
                str_vals[slot][j] = run_vals[j];
            return ST_OK;
        endfunction

        // Work out the results of one accepted item
        function void note_item(t_action act, logic [CODE_W-1:0] code,
                                logic [VAL_W-1:0] val, logic run_end);
            int slot;
            int n;
            int lim;
            if (act == ACT_STORE) begin
                if (ident) begin
                    run_len = 0;
                    if (run_end)
                        add_expect('0, 1'b0, ST_IDENT, 1'b1);
                    return;
                end
                if (run_len < STR_MAX) begin
                    run_vals[run_len] = val;
                    run_len++;
                end
                if (!run_end)
                    return;
                add_expect('0, 1'b0, commit_run(code), 1'b1);
                run_len = 0;
                return;
            end
            if (ident) begin
                add_expect(code[VAL_W-1:0], 1'b1, ST_OK, 1'b1);
                n_hits++;
            end else if (code >= MAP_DEPTH) begin
                add_expect('0, 1'b0, ST_RANGE, 1'b1);
            end else if (direct_map[code] != 0) begin
                add_expect(direct_map[code], 1'b1, ST_OK, 1'b1);
                n_hits++;
            end else begin
                slot = find_string(code);
                n = 0;
                if (slot >= 0) begin
                    lim = (limit > MAX_OUT) ? MAX_OUT : limit;
                    n = (str_len[slot] > lim) ? lim : str_len[slot];
                end
                if (n == 0)
                    add_expect('0, 1'b0, ST_OK, 1'b1);
                else begin
                    n_hits++;
                    n_string_vals += n;
                    for (int j = 0; j < n; j++)
                        add_expect(str_vals[slot][j], 1'b1, ST_OK, j == n - 1);
                end
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50)
                $display("ERROR at %0t ns: %s", $time, msg);
        endtask

        // Compare one result with the oldest expectation
        task check_result(t_map_result got);
            t_map_result want;
            n_results++;
            if (expected_unicode.size() == 0) begin
                report($sformatf("result %0d arrived with none outstanding", n_results));
                return;
            end
            want = expected_unicode.pop_front();
            if (got.value !== want.value)
                report($sformatf("result %0d value %0h, want %0h",
                                 n_results, got.value, want.value));
            if (got.found !== want.found)
                report($sformatf("result %0d found %b, want %b",
                                 n_results, got.found, want.found));
            if (got.status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 n_results, got.status, want.status));
            if (got.last !== want.last)
                report($sformatf("result %0d last %b, want %b",
                                 n_results, got.last, want.last));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cumt_in_if  req_ch ();
    cumt_out_if rsp_ch ();

    cmap_tracker tracker = new();

    int  items_sent;
    bit  steady;
    bit  hold_off_req;
    int  used_codes [$];

    code_to_unicode_map_table_unit #(
        .TABLE_DEPTH    (MAP_DEPTH),
        .STRING_ENTRIES (STR_SLOTS),
        .MAX_STRING     (STR_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Random value, biased toward zero and the top value
    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 15)
            return '1;
        return VAL_W'($urandom);
    endfunction

    // Random code: reuse of stored codes, fresh in-range codes, edges and out-of-range
    function automatic logic [CODE_W-1:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return CODE_W'($urandom_range(CODE_TOP, MAP_DEPTH));
        if (r < 12) begin
            case ($urandom_range(3))
                0: return '0;
                1: return CODE_W'(MAP_DEPTH - 1);
                2: return CODE_W'(MAP_DEPTH);
                default: return CODE_TOP;
            endcase
        end
        if (r < 60 && used_codes.size() > 0)
            return CODE_W'(used_codes[$urandom_range(used_codes.size() - 1)]);
        return CODE_W'($urandom_range(MAP_DEPTH - 1));
    endfunction

    // Offer one item, with random idle cycles ahead of it unless steady; returns at a falling edge
    task automatic send_item(t_action act, logic [CODE_W-1:0] code,
                             logic [VAL_W-1:0] val, logic fin);
        while (!steady && $urandom_range(99) < 13) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.code    <= code;
        req_ch.value   <= val;
        req_ch.run_end <= fin;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        tracker.note_item(act, code, val, fin);
        items_sent++;
        if (act == ACT_STORE && fin && code < MAP_DEPTH) begin
            used_codes.push_back(int'(code));
            if (used_codes.size() > 256)
                void'(used_codes.pop_front());
        end
        @(negedge i_clk);
    endtask

    task automatic send_run(logic [CODE_W-1:0] code, int len);
        for (int i = 0; i < len; i++)
            send_item(ACT_STORE, code, pick_value(), i == len - 1);
    endtask

    task automatic send_lookup(logic [CODE_W-1:0] code);
        send_item(ACT_LOOKUP, code, VAL_W'($urandom), 1'($urandom));
    endtask

    // Hold off until every expected result has come, then let the block go quiet
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (tracker.expected_unicode.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        tracker.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly well-formed runs and lookups, some open fragments and out-of-range runs
    task automatic random_mix(int count);
        int target;
        int r;
        int len;
        target = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 40) begin
                send_lookup(pick_code());
            end else if (r < 80) begin
                r = $urandom_range(99);
                len = (r < 40) ? 1 : (r < 90) ? $urandom_range(2, STR_MAX)
                                              : $urandom_range(STR_MAX + 1, STR_MAX + 3);
                send_run(pick_code(), len);
            end else if (r < 90) begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                    send_item(ACT_STORE, pick_code(), pick_value(), 1'b0);
            end else begin
                send_run(CODE_W'($urandom_range(CODE_TOP, MAP_DEPTH)), $urandom_range(1, 3));
            end
        end
    endtask

    // Fill the string store, overflow it, then replace an existing entry
    task automatic fill_strings();
        while (tracker.str_count < STR_SLOTS)
            send_run(CODE_W'($urandom_range(MAP_DEPTH - 1)), 2);
        repeat (3) send_run(CODE_W'($urandom_range(MAP_DEPTH - 1)), 2);
        send_run(tracker.str_code[$urandom_range(STR_SLOTS - 1)], 5);
    endtask

    // Result side: random stalls, one long hold-off on request, check each result
    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= steady || ($urandom_range(99) >= 13);
            end
        end
    end

    initial begin
        t_map_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                got = '{value: rsp_ch.result_value, found: rsp_ch.found,
                        status: rsp_ch.status, last: rsp_ch.last};
                tracker.check_result(got);
            end
        end
    end

    // Stimulus
    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.action  = ACT_STORE;
        req_ch.code    = '0;
        req_ch.value   = '0;
        req_ch.run_end = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_IDENTITY;
        i_cfg_data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty table, range edges, top value, zero store, strings, clamped run
        send_lookup('0);
        send_lookup(CODE_W'(MAP_DEPTH));
        send_lookup(CODE_TOP);
        send_item(ACT_STORE, CODE_W'(MAP_DEPTH - 1), '1, 1'b1);
        send_lookup(CODE_W'(MAP_DEPTH - 1));
        send_item(ACT_STORE, '0, '0, 1'b1);
        send_lookup('0);
        send_run(CODE_W'(5), 3);
        send_lookup(CODE_W'(5));
        send_run(CODE_W'(7), STR_MAX + 2);
        send_lookup(CODE_W'(7));
        send_item(ACT_STORE, CODE_TOP, pick_value(), 1'b1);
        drain();

        // Short string results while the result side holds off for a long stretch
        cfg_write(CFG_LIMIT, CFG_DATA_W'(3));
        hold_off_req = 1'b1;
        random_mix(50);
        drain();

        // Identity mode, upper data bits random
        cfg_write(CFG_IDENTITY, {3'($urandom), 1'b1});
        random_mix(40);
        drain();

        // Back to the table, single-value string results, no idling on either side
        cfg_write(CFG_IDENTITY, {3'($urandom), 1'b0});
        cfg_write(CFG_LIMIT, CFG_DATA_W'(1));
        steady = 1'b1;
        random_mix(40);
        steady = 1'b0;
        drain();

        // Full string store with the largest limit
        cfg_write(CFG_LIMIT, '1);
        fill_strings();
        random_mix(30);
        drain();

        cfg_write(CFG_LIMIT, '0);
        random_mix(30);
        drain();

        cfg_write(CFG_LIMIT, CFG_DATA_W'(MAX_OUT));
        random_mix(40);
        drain();

        $display("Covered %0d items and %0d results: %0d lookup hits, %0d string values,",
                 items_sent, tracker.n_results, tracker.n_hits, tracker.n_string_vals);
        $display("  %0d out-of-range, %0d store-full and %0d identity-mode store reports.",
                 tracker.n_range, tracker.n_full, tracker.n_ident);
        if (tracker.errors == 0 && tracker.expected_unicode.size() == 0)
            $display("code_to_unicode_map_table_unit: match");
        else
            $display("code_to_unicode_map_table_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("Timeout with %0d results outstanding", tracker.expected_unicode.size());
        $display("code_to_unicode_map_table_unit: mismatch");
        $finish;
    end

endmodule
